// ----- src/uqpe_pkg.sv -----
// Package for the URL query parameter extractor: types, character codes,
// the hex digit decoder and the register indexes. No dependencies.
package uqpe_pkg;

   // Sizes.
   localparam int MAX_KEY_LEN  = 8;
   localparam int MAX_RESULTS  = 4;
   localparam int KEY_BITS     = MAX_KEY_LEN * 8;
   localparam int CSR_DATA_W   = KEY_BITS;
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int RES_IDX_W    = $clog2(MAX_RESULTS);

   localparam logic [3:0] KEY_LEN_MAX = 4'(MAX_KEY_LEN);

   // Register indexes.
   localparam logic [0:0] CSR_KEY_CHARS  = 1'd0;
   localparam logic [0:0] CSR_KEY_LENGTH = 1'd1;

   // Character codes.
   localparam logic [15:0] CH_PLUS     = 16'h002B;
   localparam logic [15:0] CH_PERCENT  = 16'h0025;
   localparam logic [15:0] CH_QUESTION = 16'h003F;
   localparam logic [15:0] CH_HASH     = 16'h0023;
   localparam logic [15:0] CH_EQUAL    = 16'h003D;
   localparam logic [15:0] CH_AMP      = 16'h0026;
   localparam logic [15:0] ASCII_LIMIT = 16'd128;
   localparam logic [7:0]  BYTE_SPACE  = 8'h20;
   localparam logic [7:0]  BYTE_PERCENT = 8'h25;

   typedef enum logic [2:0] {
      PH_WAIT_Q,
      PH_NAME,
      PH_SKIP,
      PH_VALUE,
      PH_FOUND,
      PH_NOT_FOUND
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PERCENT,
      ESC_DIGIT
   } esc_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] name_index;
      logic       name_matches;
      esc_type    esc;
      logic [6:0] first_hex_char;
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_marker;
      logic       key_found;
   } res_entry_type;

   typedef res_entry_type [MAX_RESULTS-1:0] res_list_type;

   // Value of a hex digit, or 16 when the unit is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [15:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         v = 5'(c - 16'h0030);
      end else if (c >= 16'h0061 && c <= 16'h0066) begin
         v = 5'(c - 16'h0061 + 16'd10);
      end else if (c >= 16'h0041 && c <= 16'h0046) begin
         v = 5'(c - 16'h0041 + 16'd10);
      end
      return v;
   endfunction

endpackage

// ----- src/uqpe_req_if.sv -----
// Input channel of the URL query parameter extractor: one code unit per item.
// Depends on nothing.
interface uqpe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        url_end;

   modport source (output valid, output code_unit, output url_end, input ready);
   modport sink   (input valid, input code_unit, input url_end, output ready);
endinterface

// ----- src/uqpe_rsp_if.sv -----
// Result channel of the URL query parameter extractor: one byte or marker per item.
// Depends on nothing.
interface uqpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_marker;
   logic       key_found;
   logic       last_of_run;

   modport source (output valid, output data_byte, output is_marker,
                   output key_found, output last_of_run, input ready);
   modport sink   (input valid, input data_byte, input is_marker,
                   input key_found, input last_of_run, output ready);
endinterface

// ----- src/uqpe_parse.sv -----
// Parser state and one-unit decode step: turns one code unit into up to four results.
// Depends on uqpe_pkg.
module uqpe_parse (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [15:0]                        code_unit,
   input  logic                               url_end,
   input  logic [uqpe_pkg::KEY_BITS-1:0]      key_chars,
   input  logic [3:0]                         key_len,
   output uqpe_pkg::res_list_type             res_list,
   output logic [uqpe_pkg::RES_CNT_W-1:0]     res_count
);

   uqpe_pkg::parse_state_type state_ff, state_in;
   uqpe_pkg::parse_state_type st;
   uqpe_pkg::res_list_type    res_n;
   logic [uqpe_pkg::RES_CNT_W-1:0] cnt_n;
   logic [3:0] klen;
   logic [4:0] hex_c;
   logic [4:0] hex_first;
   logic       is_hex;
   logic       is_delim;
   logic       consumed;
   logic       in_value;
   logic [7:0] key_byte;

   // Reset value of the parser.
   function automatic uqpe_pkg::parse_state_type cleared();
      uqpe_pkg::parse_state_type s;
      s.phase          = uqpe_pkg::PH_WAIT_Q;
      s.name_index     = 4'd0;
      s.name_matches   = 1'b1;
      s.esc            = uqpe_pkg::ESC_NONE;
      s.first_hex_char = 7'd0;
      return s;
   endfunction

   assign klen      = (key_len > uqpe_pkg::KEY_LEN_MAX) ? uqpe_pkg::KEY_LEN_MAX : key_len;
   assign hex_c     = uqpe_pkg::hex_value(code_unit);
   assign hex_first = uqpe_pkg::hex_value({9'd0, state_ff.first_hex_char});
   assign is_hex    = (hex_c != 5'd16);
   assign is_delim  = (code_unit == uqpe_pkg::CH_AMP) || (code_unit == uqpe_pkg::CH_HASH);
   assign in_value  = (state_ff.phase == uqpe_pkg::PH_VALUE);
   assign key_byte  = key_chars[state_ff.name_index[2:0]*8 +: 8];

   // One decode step; results are appended in order.
   always_comb begin
      st       = state_ff;
      res_n    = '0;
      cnt_n    = '0;
      consumed = 1'b0;

      // Segment and name tracking outside the value.
      unique case (state_ff.phase)
         uqpe_pkg::PH_WAIT_Q: begin
            if (code_unit == uqpe_pkg::CH_QUESTION) begin
               st.phase        = uqpe_pkg::PH_NAME;
               st.name_index   = 4'd0;
               st.name_matches = 1'b1;
            end
         end
         uqpe_pkg::PH_NAME: begin
            priority if (code_unit == uqpe_pkg::CH_HASH) begin
               st.phase = uqpe_pkg::PH_NOT_FOUND;
            end else if (code_unit == uqpe_pkg::CH_AMP) begin
               st.phase        = uqpe_pkg::PH_NAME;
               st.name_index   = 4'd0;
               st.name_matches = 1'b1;
            end else if (code_unit == uqpe_pkg::CH_EQUAL) begin
               if (state_ff.name_matches && state_ff.name_index == klen) begin
                  st.phase = uqpe_pkg::PH_VALUE;
                  st.esc   = uqpe_pkg::ESC_NONE;
               end else begin
                  st.phase = uqpe_pkg::PH_SKIP;
               end
            end else if (state_ff.name_index < klen && code_unit == {8'h00, key_byte}) begin
               st.name_index = state_ff.name_index + 4'd1;
            end else begin
               st.name_matches = 1'b0;
            end
         end
         uqpe_pkg::PH_SKIP: begin
            if (code_unit == uqpe_pkg::CH_AMP) begin
               st.phase        = uqpe_pkg::PH_NAME;
               st.name_index   = 4'd0;
               st.name_matches = 1'b1;
            end else if (code_unit == uqpe_pkg::CH_HASH) begin
               st.phase = uqpe_pkg::PH_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase

      // Percent decoding of a value unit.
      if (in_value && !is_delim) begin
         unique case (state_ff.esc)
            uqpe_pkg::ESC_PERCENT: begin
               if (is_hex) begin
                  st.first_hex_char = code_unit[6:0];
                  st.esc            = uqpe_pkg::ESC_DIGIT;
                  consumed          = 1'b1;
               end else begin
                  res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{uqpe_pkg::BYTE_PERCENT, 1'b0, 1'b0};
                  cnt_n  = cnt_n + 1'b1;
                  st.esc = uqpe_pkg::ESC_NONE;
               end
            end
            uqpe_pkg::ESC_DIGIT: begin
               if (is_hex) begin
                  res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] =
                     '{{hex_first[3:0], hex_c[3:0]}, 1'b0, 1'b0};
                  cnt_n    = cnt_n + 1'b1;
                  st.esc   = uqpe_pkg::ESC_NONE;
                  consumed = 1'b1;
               end else begin
                  res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{uqpe_pkg::BYTE_PERCENT, 1'b0, 1'b0};
                  cnt_n = cnt_n + 1'b1;
                  res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] =
                     '{{1'b0, state_ff.first_hex_char}, 1'b0, 1'b0};
                  cnt_n  = cnt_n + 1'b1;
                  st.esc = uqpe_pkg::ESC_NONE;
               end
            end
            default: begin
            end
         endcase
         if (!consumed) begin
            priority if (code_unit == uqpe_pkg::CH_PERCENT) begin
               st.esc = uqpe_pkg::ESC_PERCENT;
            end else if (code_unit == uqpe_pkg::CH_PLUS) begin
               res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{uqpe_pkg::BYTE_SPACE, 1'b0, 1'b0};
               cnt_n = cnt_n + 1'b1;
            end else if (code_unit < uqpe_pkg::ASCII_LIMIT) begin
               res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{code_unit[7:0], 1'b0, 1'b0};
               cnt_n = cnt_n + 1'b1;
            end else begin
            end
         end
      end

      // End of the value: a pending escape goes out literally. A value that opens
      // on the final unit of the URL closes here too.
      if ((in_value && is_delim) || (url_end && st.phase == uqpe_pkg::PH_VALUE)) begin
         if (st.esc == uqpe_pkg::ESC_PERCENT || st.esc == uqpe_pkg::ESC_DIGIT) begin
            res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{uqpe_pkg::BYTE_PERCENT, 1'b0, 1'b0};
            cnt_n = cnt_n + 1'b1;
         end
         if (st.esc == uqpe_pkg::ESC_DIGIT) begin
            res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] = '{{1'b0, st.first_hex_char}, 1'b0, 1'b0};
            cnt_n = cnt_n + 1'b1;
         end
         st.esc   = uqpe_pkg::ESC_NONE;
         st.phase = uqpe_pkg::PH_FOUND;
      end

      // End of the URL: marker, then back to the reset state.
      if (url_end) begin
         res_n[cnt_n[uqpe_pkg::RES_IDX_W-1:0]] =
            '{8'h00, 1'b1, (st.phase == uqpe_pkg::PH_FOUND)};
         cnt_n = cnt_n + 1'b1;
         st    = cleared();
      end

      state_in = st;
   end

   assign res_list  = res_n;
   assign res_count = cnt_n;

   // Parser state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cleared();
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/uqpe_outq.sv -----
// Result register: holds the results of one code unit and hands them out one per
// cycle while rsp_ch.ready is high. Depends on uqpe_pkg and uqpe_rsp_if.
module uqpe_outq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  uqpe_pkg::res_list_type         load_list,
   input  logic [uqpe_pkg::RES_CNT_W-1:0] load_count,
   output logic                           can_load,
   uqpe_rsp_if.source                     rsp_ch
);

   uqpe_pkg::res_list_type         list_ff;
   logic [uqpe_pkg::RES_CNT_W-1:0] count_ff;
   logic [uqpe_pkg::RES_IDX_W-1:0] idx_ff;
   logic                           on_last;
   logic                           take;
   uqpe_pkg::res_entry_type        cur;

   assign on_last  = ({1'b0, idx_ff} + 1'b1) == count_ff;
   assign take     = rsp_ch.valid && rsp_ch.ready;
   assign can_load = (count_ff == '0) || (rsp_ch.ready && on_last);
   assign cur      = list_ff[idx_ff];

   // Present the current result.
   assign rsp_ch.valid       = (count_ff != '0);
   assign rsp_ch.data_byte   = cur.data_byte;
   assign rsp_ch.is_marker   = cur.is_marker;
   assign rsp_ch.key_found   = cur.key_found;
   assign rsp_ch.last_of_run = on_last;

   // Fill and drain control.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= load_count;
         idx_ff   <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + 1'b1;
         if (on_last) begin
            count_ff <= '0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         list_ff <= load_list;
      end
   end

endmodule

// ----- src/url_query_param_extractor_unit.sv -----
// Top level of the URL query parameter extractor: input register, key registers,
// parser and result register. Depends on uqpe_pkg, uqpe_req_if, uqpe_rsp_if,
// uqpe_parse and uqpe_outq.
//
//   port     direction  contents
//   req_ch   in         code_unit[15:0], url_end (valid/ready)
//   rsp_ch   out        data_byte[7:0], is_marker, key_found, last_of_run (valid/ready)
//   csr_*    in         write enable, index (0 key_chars, 1 key_length), data[63:0]
//
// One code unit is taken per cycle while the result register can load; its results
// are registered there and go out one result per cycle while rsp_ch.ready is high.
// A unit that yields two to four results holds the input while the result register
// drains. Reset is synchronous and clears the key registers and the parser state.
// A stall on rsp_ch backs up through the result register into req_ch.ready.
module url_query_param_extractor_unit (
   input  logic                               clock,
   input  logic                               reset,
   uqpe_req_if.sink                           req_ch,
   uqpe_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [0:0]                         csr_index,
   input  logic [uqpe_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                              in_valid_ff;
   logic [15:0]                       code_ff;
   logic                              end_ff;
   logic                              advance;
   logic                              can_load;
   logic [uqpe_pkg::KEY_BITS-1:0]     key_chars_ff;
   logic [3:0]                        key_length_ff;
   uqpe_pkg::res_list_type            res_list;
   logic [uqpe_pkg::RES_CNT_W-1:0]    res_count;

   assign advance      = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || advance;

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_chars_ff  <= '0;
         key_length_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            uqpe_pkg::CSR_KEY_CHARS:  key_chars_ff  <= csr_write_data;
            uqpe_pkg::CSR_KEY_LENGTH: key_length_ff <= csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         code_ff <= req_ch.code_unit;
         end_ff  <= req_ch.url_end;
      end
   end

   // Decode step.
   uqpe_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .code_unit (code_ff),
      .url_end   (end_ff),
      .key_chars (key_chars_ff),
      .key_len   (key_length_ff),
      .res_list  (res_list),
      .res_count (res_count)
   );

   // Result register.
   uqpe_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_list  (res_list),
      .load_count (res_count),
      .can_load   (can_load),
      .rsp_ch     (rsp_ch)
   );

endmodule
